FILE: src/orle_pkg.sv
`timescale 1ns / 1ps
package orle_pkg;
   localparam int Depth = 32;
   localparam int IdxW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam int KeyW = 32;
   localparam int YearW = 16;
   localparam int RecW = KeyW + YearW;
   localparam int OutLimit = 32;

   localparam logic [2:0] CMD_INS_HEAD = 3'd0;
   localparam logic [2:0] CMD_INS_POS = 3'd1;
   localparam logic [2:0] CMD_INS_TAIL = 3'd2;
   localparam logic [2:0] CMD_FIND = 3'd3;
   localparam logic [2:0] CMD_DELETE = 3'd4;
   localparam logic [2:0] CMD_SORT = 3'd5;
   localparam logic [2:0] CMD_LIST = 3'd6;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_SRCH_RD, S_SRCH_CHK,
      S_DEL_RD, S_DEL_WR, S_SORT_RDI, S_SORT_RDJ, S_SORT_CMP, S_SORT_WRJ,
      S_LIST_RD, S_LIST_OUT, S_RESP
   } state_type;

   typedef struct packed {
      logic ld_req;
      logic [1:0] addr_sel;   // 0 ptr_i, 1 ptr_j, 2 ptr_i-1, 3 ptr_i+1
      logic we;
      logic [1:0] wd_sel;     // 0 request, 1 rdata, 2 hold reg, 3 i hold reg
      logic hold_ld;
      logic hold_i_ld;
      logic i_ld_zero;
      logic i_ld_cnt;
      logic i_ld_ins;
      logic i_inc;
      logic i_dec;
      logic j_ld;
      logic j_inc;
      logic cnt_inc;
      logic cnt_dec;
      logic rsp_ld;
      logic [1:0] rsp_status;
      logic rsp_rec;          // 1 take record, 0 zero
      logic rsp_from_req;
      logic rsp_last;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic full;
      logic empty;
      logic i_at_end;       // ptr_i == count
      logic i_le_ins;       // ptr_i <= insert index
      logic i_next_end;     // ptr_i + 1 >= count
      logic j_at_end;
      logic i_last_list;
      logic key_hit;
      logic less;
      logic rsp_busy;
   } sts_type;
endpackage

FILE: src/orle_ram.sv
`timescale 1ns / 1ps
module orle_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0] wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];
   // A read of the address being written returns the new word.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (we && waddr == raddr) rdata <= wdata;
      else rdata <= mem[raddr];
   end
endmodule

FILE: src/orle_datapath.sv
`timescale 1ns / 1ps
module orle_datapath import orle_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  ctl_type ctl,
   output sts_type sts,
   input  logic [2:0] req_cmd,
   input  logic signed [KeyW-1:0] req_key,
   input  logic [YearW-1:0] req_year,
   input  logic [7:0] req_position,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic signed [KeyW-1:0] rsp_found_key,
   output logic [YearW-1:0] rsp_found_year,
   output logic [4:0] rsp_entry_index,
   output logic rsp_last
);
   logic [2:0] cmd_ff;
   logic [KeyW-1:0] key_ff;
   logic [YearW-1:0] year_ff;
   logic [CntW-1:0] ins_ff, ins_in;
   logic [CntW-1:0] cnt_ff, i_ff, j_ff;
   logic [RecW-1:0] hold_ff, hold_i_ff, rdata, wdata;
   logic [IdxW-1:0] addr;
   logic [CntW-1:0] a_full;
   logic v_ff;
   logic [1:0] st_ff;
   logic [KeyW-1:0] k_ff;
   logic [YearW-1:0] y_ff;
   logic [4:0] x_ff;
   logic l_ff;
   logic [8:0] after;
   logic [CntW-1:0] lim;

   always_comb begin
      after = (req_position == 8'd0) ? 9'd0 : {1'b0, req_position} - 9'd1;
      if (cnt_ff == '0 || req_cmd == CMD_INS_HEAD) ins_in = '0;
      else if (req_cmd == CMD_INS_TAIL) ins_in = cnt_ff;
      else if (after > 9'(cnt_ff - 1'b1)) ins_in = cnt_ff;
      else ins_in = CntW'(after + 9'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else if (ctl.cnt_inc) cnt_ff <= cnt_ff + 1'b1;
      else if (ctl.cnt_dec) cnt_ff <= cnt_ff - 1'b1;
      if (ctl.ld_req) begin
         cmd_ff <= req_cmd; key_ff <= req_key; year_ff <= req_year;
         ins_ff <= ins_in;
      end
      if (ctl.i_ld_zero) i_ff <= '0;
      else if (ctl.i_ld_cnt) i_ff <= cnt_ff;
      else if (ctl.i_ld_ins) i_ff <= ins_ff;
      else if (ctl.i_inc) i_ff <= i_ff + 1'b1;
      else if (ctl.i_dec) i_ff <= i_ff - 1'b1;
      if (ctl.j_ld) j_ff <= i_ff + 1'b1;
      else if (ctl.j_inc) j_ff <= j_ff + 1'b1;
      if (ctl.hold_ld) hold_ff <= rdata;
      if (ctl.hold_i_ld) hold_i_ff <= rdata;
   end

   always_comb begin
      case (ctl.addr_sel)
         2'd0: a_full = i_ff;
         2'd1: a_full = j_ff;
         2'd2: a_full = i_ff - 1'b1;
         default: a_full = i_ff + 1'b1;
      endcase
      addr = a_full[IdxW-1:0];
      case (ctl.wd_sel)
         2'd0: wdata = {key_ff, year_ff};
         2'd1: wdata = rdata;
         2'd2: wdata = hold_ff;
         default: wdata = hold_i_ff;
      endcase
   end

   orle_ram #(.Width(RecW), .Depth(Depth)) u_ram (
      .clock(clock), .we(ctl.we), .waddr(addr), .wdata(wdata),
      .raddr(addr), .rdata(rdata)
   );

   always_comb begin
      lim = (cnt_ff > CntW'(OutLimit)) ? CntW'(OutLimit) : cnt_ff;
      sts.cmd = cmd_ff;
      sts.full = (cnt_ff == CntW'(Depth));
      sts.empty = (cnt_ff == '0);
      sts.i_at_end = (i_ff == cnt_ff);
      sts.i_le_ins = (i_ff <= ins_ff);
      sts.i_next_end = ((i_ff + 1'b1) >= cnt_ff);
      sts.j_at_end = (j_ff >= cnt_ff);
      sts.i_last_list = ((i_ff + 1'b1) == lim);
      sts.key_hit = (rdata[RecW-1:YearW] == key_ff);
      sts.less = $signed(rdata[RecW-1:YearW]) < $signed(hold_i_ff[RecW-1:YearW]);
      sts.rsp_busy = v_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (ctl.rsp_ld) v_ff <= 1'b1;
      else if (!rsp_stall) v_ff <= 1'b0;
      if (ctl.rsp_ld) begin
         st_ff <= ctl.rsp_status;
         l_ff <= ctl.rsp_last;
         if (ctl.rsp_from_req) begin
            k_ff <= key_ff; y_ff <= year_ff; x_ff <= ins_ff[4:0];
         end else if (ctl.rsp_rec) begin
            k_ff <= rdata[RecW-1:YearW]; y_ff <= rdata[YearW-1:0];
            x_ff <= i_ff[4:0];
         end else begin
            k_ff <= '0; y_ff <= '0; x_ff <= '0;
         end
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_status = st_ff;
   assign rsp_found_key = k_ff;
   assign rsp_found_year = y_ff;
   assign rsp_entry_index = x_ff;
   assign rsp_last = l_ff;
endmodule

FILE: src/orle_ctrl.sv
`timescale 1ns / 1ps
module orle_ctrl import orle_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  sts_type sts,
   output ctl_type ctl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.ld_req = 1'b1;
               ctl.i_ld_zero = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // Dispatch on the latched command.
            case (sts.cmd)
               CMD_INS_HEAD, CMD_INS_POS, CMD_INS_TAIL: begin
                  if (sts.full) begin
                     if (!sts.rsp_busy) begin
                        ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_FULL;
                        ctl.rsp_last = 1'b1; state_in = S_IDLE;
                     end
                  end else begin
                     ctl.i_ld_cnt = 1'b1; state_in = S_SHIFT_RD;
                  end
               end
               CMD_FIND, CMD_DELETE: begin
                  if (sts.cmd == CMD_DELETE && sts.empty) begin
                     if (!sts.rsp_busy) begin
                        ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_EMPTY;
                        ctl.rsp_last = 1'b1; state_in = S_IDLE;
                     end
                  end else state_in = S_SRCH_RD;
               end
               CMD_SORT: state_in = S_SORT_RDI;
               CMD_LIST: begin
                  if (sts.empty) begin
                     if (!sts.rsp_busy) begin
                        ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_EMPTY;
                        ctl.rsp_last = 1'b1; state_in = S_IDLE;
                     end
                  end else state_in = S_LIST_RD;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SHIFT_RD: begin
            // Move entries up one slot, from the tail down to the insert point.
            if (sts.i_le_ins) begin
               ctl.i_ld_ins = 1'b1; state_in = S_PUT;
            end else begin
               ctl.addr_sel = 2'd2; state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ctl.addr_sel = 2'd0; ctl.we = 1'b1; ctl.wd_sel = 2'd1;
            ctl.i_dec = 1'b1; state_in = S_SHIFT_RD;
         end
         S_PUT: begin
            if (!sts.rsp_busy) begin
               ctl.addr_sel = 2'd0; ctl.we = 1'b1; ctl.wd_sel = 2'd0;
               ctl.cnt_inc = 1'b1;
               ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_OK; ctl.rsp_from_req = 1'b1;
               ctl.rsp_last = 1'b1; state_in = S_IDLE;
            end
         end
         S_SRCH_RD: begin
            if (sts.i_at_end) begin
               if (!sts.rsp_busy) begin
                  ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_MISS;
                  ctl.rsp_last = 1'b1; state_in = S_IDLE;
               end
            end else begin
               ctl.addr_sel = 2'd0; state_in = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (!sts.key_hit) begin
               ctl.i_inc = 1'b1; state_in = S_SRCH_RD;
            end else if (!sts.rsp_busy) begin
               ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_OK; ctl.rsp_rec = 1'b1;
               ctl.rsp_last = 1'b1;
               state_in = (sts.cmd == CMD_DELETE) ? S_DEL_RD : S_IDLE;
            end else begin
               ctl.addr_sel = 2'd0;   // keep the read word stable
            end
         end
         S_DEL_RD: begin
            if (sts.i_next_end) begin
               ctl.cnt_dec = 1'b1; state_in = S_IDLE;
            end else begin
               ctl.addr_sel = 2'd3; state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            ctl.addr_sel = 2'd0; ctl.we = 1'b1; ctl.wd_sel = 2'd1;
            ctl.i_inc = 1'b1; state_in = S_DEL_RD;
         end
         S_SORT_RDI: begin
            if (sts.i_at_end) begin
               if (!sts.rsp_busy) begin
                  ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_OK;
                  ctl.rsp_last = 1'b1; state_in = S_IDLE;
               end
            end else begin
               ctl.addr_sel = 2'd0; ctl.j_ld = 1'b1; state_in = S_SORT_RDJ;
            end
         end
         S_SORT_RDJ: begin
            // The i word arrives now; it is the running minimum for slot i.
            ctl.hold_i_ld = 1'b1;
            if (sts.j_at_end) begin
               ctl.i_inc = 1'b1; state_in = S_SORT_RDI;
            end else begin
               ctl.addr_sel = 2'd1; state_in = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            if (sts.less) begin
               ctl.hold_ld = 1'b1;
               ctl.addr_sel = 2'd1; ctl.we = 1'b1; ctl.wd_sel = 2'd3;
               state_in = S_SORT_WRJ;
            end else begin
               ctl.j_inc = 1'b1; state_in = S_SORT_RDJ;
               ctl.addr_sel = 2'd0;
            end
         end
         S_SORT_WRJ: begin
            // hold_ff has the j word; swap: j <- old i, i <- j word.
            ctl.addr_sel = 2'd0; ctl.we = 1'b1; ctl.wd_sel = 2'd2;
            ctl.j_inc = 1'b1; state_in = S_SORT_RDJ;
         end
         S_LIST_RD: begin
            ctl.addr_sel = 2'd0; state_in = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            ctl.addr_sel = 2'd0;
            if (!sts.rsp_busy) begin
               ctl.rsp_ld = 1'b1; ctl.rsp_status = ST_OK; ctl.rsp_rec = 1'b1;
               ctl.rsp_last = sts.i_last_list;
               if (sts.i_last_list) state_in = S_IDLE;
               else begin
                  ctl.i_inc = 1'b1; state_in = S_LIST_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

FILE: src/ordered_record_list_engine.sv
`timescale 1ns / 1ps
// Ordered list of up to Depth records (signed key, year) in a single-port-style
// RAM walked by a controller one entry at a time. An item shifts, searches or
// lists entries one by one; a sort visits every (i, j) pair for each i.
// Every word on the rsp_ channel is held in an output register, and a new
// req_ word is taken only when the previous command is complete.
module ordered_record_list_engine import orle_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_cmd,
   input  logic signed [31:0] req_key,
   input  logic [15:0] req_year,
   input  logic [7:0] req_position,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_found_key,
   output logic [15:0] rsp_found_year,
   output logic [4:0] rsp_entry_index,
   output logic rsp_last
);
   ctl_type ctl;
   sts_type sts;

   orle_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .sts(sts), .ctl(ctl)
   );

   orle_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .req_cmd(req_cmd), .req_key(req_key), .req_year(req_year),
      .req_position(req_position), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_found_key(rsp_found_key), .rsp_found_year(rsp_found_year),
      .rsp_entry_index(rsp_entry_index), .rsp_last(rsp_last)
   );
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb import orle_pkg::*; ();

   typedef struct packed {
      logic [1:0] status;
      logic [31:0] key;
      logic [15:0] year;
      logic [4:0] idx;
      logic last;
   } outcome_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_cmd = '0;
   logic signed [31:0] req_key = '0;
   logic [15:0] req_year = '0;
   logic [7:0] req_position = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_found_key;
   logic [15:0] rsp_found_year;
   logic [4:0] rsp_entry_index;
   logic rsp_last;

   ordered_record_list_engine i_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Shadow copy of the list contents.
   logic [31:0] list_keys[Depth];
   logic [15:0] list_years[Depth];
   int list_len;
   outcome_type pending[$];
   int mismatches;
   bit idle_on = 1;
   int quiet_cycles;
   bit rsp_paused;
   int burst_left;

   function automatic bit key_below(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic int find_first(logic [31:0] k);
      for (int i = 0; i < list_len; i++)
         if (list_keys[i] == k) return i;
      return list_len;
   endfunction

   function automatic outcome_type mk(logic [1:0] s, logic [31:0] k, logic [15:0] y,
                                      int i, bit l);
      outcome_type o;
      o.status = s; o.key = k; o.year = y; o.idx = i[4:0]; o.last = l;
      return o;
   endfunction

   task automatic predict_command(logic [2:0] c, logic [31:0] k, logic [15:0] y,
                                  logic [7:0] p);
      int at, after, n;
      logic [31:0] tk;
      logic [15:0] ty;
      case (c)
         CMD_INS_HEAD, CMD_INS_POS, CMD_INS_TAIL: begin
            if (list_len >= Depth) begin
               pending.push_back(mk(ST_FULL, 0, 0, 0, 1));
            end else begin
               if (c == CMD_INS_HEAD || list_len == 0) at = 0;
               else if (c == CMD_INS_TAIL) at = list_len;
               else begin
                  after = (p > 0) ? p - 1 : 0;
                  if (after > list_len - 1) after = list_len - 1;
                  at = after + 1;
               end
               for (int i = list_len; i > at; i--) begin
                  list_keys[i] = list_keys[i-1];
                  list_years[i] = list_years[i-1];
               end
               list_keys[at] = k;
               list_years[at] = y;
               list_len++;
               pending.push_back(mk(ST_OK, k, y, at, 1));
            end
         end
         CMD_FIND: begin
            at = find_first(k);
            if (at >= list_len) pending.push_back(mk(ST_MISS, 0, 0, 0, 1));
            else pending.push_back(mk(ST_OK, list_keys[at], list_years[at], at, 1));
         end
         CMD_DELETE: begin
            at = find_first(k);
            if (list_len == 0) pending.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
            else if (at >= list_len) pending.push_back(mk(ST_MISS, 0, 0, 0, 1));
            else begin
               pending.push_back(mk(ST_OK, list_keys[at], list_years[at], at, 1));
               for (int i = at; i + 1 < list_len; i++) begin
                  list_keys[i] = list_keys[i+1];
                  list_years[i] = list_years[i+1];
               end
               list_len--;
            end
         end
         CMD_SORT: begin
            for (int i = 0; i < list_len; i++)
               for (int j = i + 1; j < list_len; j++)
                  if (key_below(list_keys[j], list_keys[i])) begin
                     tk = list_keys[i]; ty = list_years[i];
                     list_keys[i] = list_keys[j]; list_years[i] = list_years[j];
                     list_keys[j] = tk; list_years[j] = ty;
                  end
            pending.push_back(mk(ST_OK, 0, 0, 0, 1));
         end
         CMD_LIST: begin
            n = (list_len > OutLimit) ? OutLimit : list_len;
            if (n == 0) pending.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
            for (int i = 0; i < n; i++)
               pending.push_back(mk(ST_OK, list_keys[i], list_years[i], i, i + 1 == n));
         end
         default: ;
      endcase
   endtask

   // The word stays valid after acceptance; it is dropped only before a gap or in drain().
   task automatic send_word(logic [2:0] c, logic [31:0] k, logic [15:0] y,
                            logic [7:0] p);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= c;
      req_key <= k;
      req_year <= y;
      req_position <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(c, k, y, p);
   endtask

   // Receiver: random stall bursts.
   always @(posedge clock) begin
      int burst;
      if (!reset) begin
         if (rsp_paused) begin
            if (burst_left == 0) begin
               rsp_stall <= 0;
               rsp_paused = 0;
            end else burst_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 7);
            burst_left = burst - 1;
            rsp_stall <= 1;
            rsp_paused = 1;
         end
      end
   end

   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_found_key, rsp_found_year, rsp_entry_index, rsp_last};
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", got);
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("[ordered_record_list_engine] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] some_key();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return $urandom_range(0, 15) - 8;
      endcase
   endfunction

   function automatic logic [31:0] existing_key();
      if (list_len == 0 || $urandom_range(0, 3) == 0) return some_key();
      return list_keys[$urandom_range(0, list_len - 1)];
   endfunction

   task automatic drain();
      req_valid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic test_empty_cases();
      send_word(CMD_LIST, 0, 0, 0);
      send_word(CMD_DELETE, 5, 0, 0);
      send_word(CMD_FIND, 5, 0, 0);
      send_word(CMD_SORT, 0, 0, 0);
      send_word(3'd7, 32'hffff_ffff, 16'hffff, 8'hff);
      send_word(CMD_INS_POS, 32'h7fff_ffff, 16'hffff, 8'hff);
      send_word(CMD_INS_HEAD, 32'h8000_0000, 16'h0000, 0);
      send_word(CMD_INS_TAIL, -1, 16'h1234, 0);
      send_word(CMD_INS_POS, 7, 16'h5555, 8'd0);
      send_word(CMD_INS_POS, 9, 16'haaaa, 8'd2);
      send_word(CMD_FIND, -1, 0, 0);
      send_word(CMD_FIND, 3, 0, 0);
      send_word(CMD_LIST, 0, 0, 0);
      send_word(CMD_SORT, 0, 0, 0);
      send_word(CMD_LIST, 0, 0, 0);
      send_word(CMD_DELETE, 32'h8000_0000, 0, 0);
      send_word(CMD_DELETE, 12345, 0, 0);
   endtask

   task automatic test_full_list();
      // The sender waits here until every expected word has arrived.
      drain();
      while (list_len < Depth) send_word(CMD_INS_TAIL, some_key(), 16'($urandom), 0);
      send_word(CMD_INS_HEAD, 1, 1, 0);
      send_word(CMD_INS_POS, 2, 2, 8'd3);
      send_word(CMD_LIST, 0, 0, 0);
      send_word(CMD_SORT, 0, 0, 0);
      send_word(CMD_LIST, 0, 0, 0);
   endtask

   task automatic test_random_mix(int count);
      logic [2:0] c;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0, 1, 2: c = CMD_INS_HEAD;
            3, 4, 5: c = CMD_INS_POS;
            6, 7, 8: c = CMD_INS_TAIL;
            9, 10, 11: c = CMD_FIND;
            12, 13, 14, 15: c = CMD_DELETE;
            16: c = CMD_SORT;
            17, 18: c = CMD_LIST;
            default: c = 3'd7;
         endcase
         send_word(c, (c == CMD_FIND || c == CMD_DELETE) ? existing_key() : some_key(),
                   16'($urandom),
                   8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_empty_cases();
      test_full_list();
      test_random_mix(120);
      drain();
      idle_on = 0;
      test_random_mix(50);
      drain();
      if (mismatches == 0 && pending.size() == 0)
         $display("[ordered_record_list_engine] OK");
      else
         $display("[ordered_record_list_engine] ERROR");
      $finish;
   end
endmodule

FILE: ordered_record_list_engine.f
src/orle_pkg.sv
src/orle_ram.sv
src/orle_datapath.sv
src/orle_ctrl.sv
src/ordered_record_list_engine.sv
bench/tb.sv
